// File: rtl/pfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants and control/status types of the padded frame deframer.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int ID_BYTES   = 16;
  localparam int ID_IDX_W   = $clog2(ID_BYTES);
  localparam int ID_W       = 8 * ID_BYTES;
  localparam int HEAD_BYTES = 5;
  localparam int HEAD_CNT_W = $clog2(HEAD_BYTES);
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  // frame commands
  localparam logic [7:0] CMD_CONTINUE = 8'd0;
  localparam logic [7:0] CMD_END      = 8'd1;
  localparam logic [7:0] CMD_DIRECT   = 8'd2;

  // register select, taken from paddr[3]
  localparam logic REG_ID_HIGH = 1'b0;
  localparam logic REG_ID_LOW  = 1'b1;

  typedef struct packed {
    logic store_id;
    logic store_head;
    logic load_frame;
    logic dec_data;
    logic dec_pad;
    logic set_error;
    logic replay_start;
    logic replay_step;
    logic out_load;
    logic out_has;
    logic out_replay;
    logic out_last;
    logic out_pass;
  } pfd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic id_full;
    logic id_match;
    logic data_nz;
    logic pad_nz;
    logic head_full;
    logic cmd_bad;
    logic frame_done;
    logic replay_last;
  } pfd_status_t;

endpackage

// File: rtl/pfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_if
// Byte input channel and result output channel of the deframer.
// ----------------------------------------------------------------------------
interface pfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface pfd_out_if;
  logic       valid;
  logic       ready;
  logic       has_data;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       passthrough_now;
  logic       direct_seen;
  logic       proto_error;

  modport source (output valid, output has_data, output out_byte, output last_of_run,
                  output passthrough_now, output direct_seen, output proto_error,
                  input ready);
  modport sink   (input valid, input has_data, input out_byte, input last_of_run,
                  input passthrough_now, input direct_seen, input proto_error,
                  output ready);
endinterface

// File: rtl/pfd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_regs
// APB register file holding the 128-bit frame identifier.
// ----------------------------------------------------------------------------
module pfd_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [pfd_pkg::ID_W-1:0]       id_ref
);

  logic [pfd_pkg::CFG_DATA_W-1:0] id_high;
  logic [pfd_pkg::CFG_DATA_W-1:0] id_low;
  logic                           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_high <= '0;
      id_low  <= '0;
    end else if (wr_en) begin
      case (paddr[3])
        pfd_pkg::REG_ID_HIGH: id_high <= pwdata;
        pfd_pkg::REG_ID_LOW:  id_low  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      pfd_pkg::REG_ID_HIGH: prdata = id_high;
      pfd_pkg::REG_ID_LOW:  prdata = id_low;
      default:              prdata = '0;
    endcase
  end

  assign id_ref = {id_high, id_low};

endmodule

// File: rtl/pfd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_dp
// Datapath: identifier and header capture, frame counters, flags, result reg.
// ----------------------------------------------------------------------------
module pfd_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [7:0]                in_byte,
  input  logic [pfd_pkg::ID_W-1:0]  id_ref,
  input  pfd_pkg::pfd_cmd_t         cmd,
  output pfd_pkg::pfd_status_t      status,
  pfd_out_if.source                 out_ch
);

  logic [7:0]                        id_store [pfd_pkg::ID_BYTES];
  logic [pfd_pkg::ID_IDX_W-1:0]      id_count;
  logic [7:0]                        head_store [pfd_pkg::HEAD_BYTES-1];
  logic [pfd_pkg::HEAD_CNT_W-1:0]    head_count;
  logic [15:0]                       data_remaining;
  logic [15:0]                       pad_remaining;
  logic                              end_pending;
  logic                              direct_flag;
  logic                              error_flag;
  logic [pfd_pkg::ID_IDX_W-1:0]      replay_idx;

  logic [pfd_pkg::ID_W-1:0]          id_word;
  logic [15:0]                       hdr_data;
  logic [15:0]                       hdr_pad;
  logic                              direct_next;
  logic                              error_next;
  logic [7:0]                        out_sel;

  logic                              out_valid;
  logic                              out_has;
  logic [7:0]                        out_byte_q;
  logic                              out_last;
  logic                              out_pass;
  logic                              out_direct;
  logic                              out_error;

  // gathered identifier, the current byte being the last one
  always_comb begin
    id_word = '0;
    for (int i = 0; i < pfd_pkg::ID_BYTES - 1; i++) begin
      id_word[pfd_pkg::ID_W-1-8*i -: 8] = id_store[i];
    end
    id_word[7:0] = in_byte;
  end

  assign hdr_data = {head_store[1], head_store[2]};
  assign hdr_pad  = {head_store[3], in_byte};

  always_comb begin
    status.out_free    = !out_valid || out_ch.ready;
    status.id_full     = (id_count == pfd_pkg::ID_IDX_W'(pfd_pkg::ID_BYTES - 1));
    status.id_match    = (id_word == id_ref);
    status.data_nz     = (data_remaining != 16'd0);
    status.pad_nz      = (pad_remaining != 16'd0);
    status.head_full   = (head_count == pfd_pkg::HEAD_CNT_W'(pfd_pkg::HEAD_BYTES - 1));
    status.cmd_bad     = (head_store[0] > pfd_pkg::CMD_DIRECT);
    status.replay_last = (replay_idx == pfd_pkg::ID_IDX_W'(pfd_pkg::ID_BYTES - 1));
    // end of an end/direct frame after the step the controller takes now
    if (data_remaining != 16'd0) begin
      status.frame_done = end_pending && (data_remaining == 16'd1) &&
                          (pad_remaining == 16'd0);
    end else if (pad_remaining != 16'd0) begin
      status.frame_done = end_pending && (pad_remaining == 16'd1);
    end else begin
      status.frame_done = (head_store[0] != pfd_pkg::CMD_CONTINUE) &&
                          (hdr_data == 16'd0) && (hdr_pad == 16'd0);
    end
  end

  assign direct_next = direct_flag ||
                       (cmd.load_frame && (head_store[0] == pfd_pkg::CMD_DIRECT));
  assign error_next  = error_flag || cmd.set_error;
  assign out_sel     = cmd.out_replay ? id_store[replay_idx] : in_byte;

  // byte stores, no reset
  always_ff @(posedge clk) begin
    if (cmd.store_id) begin
      id_store[id_count] <= in_byte;
    end
    if (cmd.store_head) begin
      head_store[head_count[pfd_pkg::HEAD_CNT_W-2:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_count       <= '0;
      head_count     <= '0;
      data_remaining <= '0;
      pad_remaining  <= '0;
      end_pending    <= 1'b0;
      direct_flag    <= 1'b0;
      error_flag     <= 1'b0;
      replay_idx     <= '0;
    end else begin
      if (cmd.store_id) begin
        id_count <= id_count + 1'b1;  // wraps to zero after the last byte
      end
      if (cmd.store_head) begin
        head_count <= head_count + 1'b1;
      end else if (cmd.load_frame || cmd.set_error) begin
        head_count <= '0;
      end
      if (cmd.load_frame) begin
        data_remaining <= hdr_data;
        pad_remaining  <= hdr_pad;
        end_pending    <= (head_store[0] != pfd_pkg::CMD_CONTINUE);
      end else begin
        if (cmd.dec_data) data_remaining <= data_remaining - 16'd1;
        if (cmd.dec_pad)  pad_remaining  <= pad_remaining - 16'd1;
      end
      direct_flag <= direct_next;
      error_flag  <= error_next;
      if (cmd.replay_start) begin
        replay_idx <= '0;
      end else if (cmd.replay_step) begin
        replay_idx <= replay_idx + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_has    <= cmd.out_has;
      out_byte_q <= cmd.out_has ? out_sel : 8'd0;
      out_last   <= cmd.out_last;
      out_pass   <= cmd.out_pass;
      out_direct <= direct_next;
      out_error  <= error_next;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.has_data        = out_has;
  assign out_ch.out_byte        = out_byte_q;
  assign out_ch.last_of_run     = out_last;
  assign out_ch.passthrough_now = out_pass;
  assign out_ch.direct_seen     = out_direct;
  assign out_ch.proto_error     = out_error;

endmodule

// File: rtl/pfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_ctrl
// Phase controller: identifier check, frame parsing, replay, passthrough.
// ----------------------------------------------------------------------------
module pfd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pfd_pkg::pfd_status_t status,
  output pfd_pkg::pfd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_GATHER,
    S_FRAMES,
    S_PASS,
    S_ERROR,
    S_REPLAY
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = status.out_free && (state != S_REPLAY);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.out_last = 1'b1;
    state_next   = state;
    case (state)
      S_GATHER: begin
        if (accept) begin
          cmd.store_id = 1'b1;
          if (status.id_full) begin
            if (status.id_match) begin
              cmd.out_load = 1'b1;
              state_next   = S_FRAMES;
            end else begin
              // no result now; the 16 gathered bytes follow
              cmd.replay_start = 1'b1;
              state_next       = S_REPLAY;
            end
          end else begin
            cmd.out_load = 1'b1;
          end
        end
      end
      S_FRAMES: begin
        if (accept) begin
          cmd.out_load = 1'b1;
          if (status.data_nz) begin
            cmd.dec_data = 1'b1;
            cmd.out_has  = 1'b1;
            if (status.frame_done) state_next = S_PASS;
          end else if (status.pad_nz) begin
            cmd.dec_pad = 1'b1;
            if (status.frame_done) state_next = S_PASS;
          end else if (!status.head_full) begin
            cmd.store_head = 1'b1;
          end else if (status.cmd_bad) begin
            cmd.set_error = 1'b1;
            state_next    = S_ERROR;
          end else begin
            cmd.load_frame = 1'b1;
            if (status.frame_done) state_next = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (accept) begin
          cmd.out_load = 1'b1;
          cmd.out_has  = 1'b1;
        end
      end
      S_ERROR: begin
        if (accept) begin
          cmd.out_load = 1'b1;
        end
      end
      S_REPLAY: begin
        if (status.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_has     = 1'b1;
          cmd.out_replay  = 1'b1;
          cmd.replay_step = 1'b1;
          cmd.out_last    = status.replay_last;
          if (status.replay_last) state_next = S_PASS;
        end
      end
      default: begin
        state_next = S_GATHER;
      end
    endcase
    cmd.out_pass = (state_next == S_PASS) || (state == S_REPLAY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_GATHER;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/padded_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_frame_deframer
// Unwraps a byte stream led by a 16-byte identifier and padded frames.
// ----------------------------------------------------------------------------
// One received byte is taken per clock in every phase and yields one result
// through a single output register, so the input moves whenever that register
// is empty or being drained. An identifier mismatch is the exception: the
// gathered 16 bytes come back from the identifier store as 16 results, one per
// cycle while the output register is free, and no input is taken. Frame
// headers are 5 bytes (command, 16-bit data length, 16-bit padding length,
// big endian); data bytes come out with has_data set, padding and header
// bytes give a result with has_data clear. The identifier sits in two 64-bit
// registers, id_high at byte address 0 and id_low at 8; paddr[3] selects.
// ----------------------------------------------------------------------------
module padded_frame_deframer (
  input  logic                           clk,
  input  logic                           rst,
  pfd_in_if.sink                         in_ch,
  pfd_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [pfd_pkg::ID_W-1:0] id_ref;
  pfd_pkg::pfd_cmd_t        cmd;
  pfd_pkg::pfd_status_t     status;

  pfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .id_ref  (id_ref)
  );

  pfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfd_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_ch.in_byte),
    .id_ref  (id_ref),
    .cmd     (cmd),
    .status  (status),
    .out_ch  (out_ch)
  );

endmodule
